FILE: src/psd_pkg.sv
// shared widths, word types and carry structs for the point to segment distance unit
// no dependencies
package psd_pkg;

  localparam int COORD_WIDTH     = 24;
  localparam int T_FRACTION_BITS = 16;

  localparam int DIST_W  = 25;
  localparam int TOUT_W  = 17;
  localparam int D_W     = COORD_WIDTH + 1;
  localparam int LEN_W   = 2 * D_W;
  localparam int DOT_W   = LEN_W + 2;
  localparam int TF_W    = T_FRACTION_BITS + 1;
  localparam int PROD_W  = D_W + TF_W;
  localparam int DX_W    = D_W + 1;
  localparam int SQ_W    = 2 * DX_W + 1;
  localparam int RT_W    = COORD_WIDTH + 3;
  localparam int CMP_W   = 2 * RT_W + 1;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
  } psd_query_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [TOUT_W-1:0] t_fraction;
    logic              zero_length;
  } psd_result_t;

  typedef struct packed {
    logic signed [D_W-1:0] apx;
    logic signed [D_W-1:0] apy;
    logic signed [D_W-1:0] abx;
    logic signed [D_W-1:0] aby;
    logic                  zero_length;
    logic                  t_one;
    logic                  t_zero;
  } psd_carry_t;

  typedef struct packed {
    logic [TF_W-1:0] t_fraction;
    logic            zero_length;
  } psd_tag_t;

endpackage

FILE: src/psd_div.sv
// pipelined restoring divider for the projection ratio, one quotient bit per stage
// depends on psd_pkg
module psd_div import psd_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [LEN_W-1:0]           in_rem,
  input  logic [LEN_W-1:0]           in_den,
  input  psd_carry_t                 in_carry,
  output logic                       out_valid,
  output logic [T_FRACTION_BITS-1:0] out_q,
  output psd_carry_t                 out_carry
);

  logic                       vld   [T_FRACTION_BITS];
  logic [LEN_W-1:0]           rem   [T_FRACTION_BITS];
  logic [LEN_W-1:0]           den   [T_FRACTION_BITS];
  logic [T_FRACTION_BITS-1:0] quo   [T_FRACTION_BITS];
  psd_carry_t                 carry [T_FRACTION_BITS];

  for (genvar k = 0; k < T_FRACTION_BITS; k++) begin : g_stage
    logic                       v_in;
    logic [LEN_W-1:0]           r_in;
    logic [LEN_W-1:0]           d_in;
    logic [T_FRACTION_BITS-1:0] q_in;
    psd_carry_t                 c_in;
    logic [LEN_W:0]             r2;
    logic                       ge;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = in_rem;
      assign d_in = in_den;
      assign q_in = '0;
      assign c_in = in_carry;
    end else begin : g_next
      assign v_in = vld[k-1];
      assign r_in = rem[k-1];
      assign d_in = den[k-1];
      assign q_in = quo[k-1];
      assign c_in = carry[k-1];
    end

    assign r2 = {r_in, 1'b0};
    assign ge = r2 >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_in;
      end
      if (en) begin
        rem[k]   <= ge ? LEN_W'(r2 - {1'b0, d_in}) : LEN_W'(r2);
        den[k]   <= d_in;
        quo[k]   <= {q_in[T_FRACTION_BITS-2:0], ge};
        carry[k] <= c_in;
      end
    end
  end

  assign out_valid = vld[T_FRACTION_BITS-1];
  assign out_q     = quo[T_FRACTION_BITS-1];
  assign out_carry = carry[T_FRACTION_BITS-1];

endmodule

FILE: src/psd_sqrt.sv
// pipelined integer square root, one root bit per stage, truncating
// depends on psd_pkg
module psd_sqrt import psd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [SQ_W-1:0] in_sq,
  input  psd_tag_t        in_tag,
  output logic            out_valid,
  output logic [RT_W-1:0] out_root,
  output psd_tag_t        out_tag
);

  logic             vld  [RT_W];
  logic [SQ_W-1:0]  s    [RT_W];
  logic [RT_W-1:0]  root [RT_W];
  logic [CMP_W-1:0] rsq  [RT_W];
  psd_tag_t         tag  [RT_W];

  for (genvar k = 0; k < RT_W; k++) begin : g_stage
    localparam int B = RT_W - 1 - k;
    logic             v_in;
    logic [SQ_W-1:0]  s_in;
    logic [RT_W-1:0]  r_in;
    logic [CMP_W-1:0] q_in;
    psd_tag_t         t_in;
    logic [CMP_W-1:0] trial;
    logic             take;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign s_in = in_sq;
      assign r_in = '0;
      assign q_in = '0;
      assign t_in = in_tag;
    end else begin : g_next
      assign v_in = vld[k-1];
      assign s_in = s[k-1];
      assign r_in = root[k-1];
      assign q_in = rsq[k-1];
      assign t_in = tag[k-1];
    end

    assign trial = q_in + (CMP_W'(r_in) << (B + 1)) + (CMP_W'(1) << (2 * B));
    assign take  = trial <= CMP_W'(s_in);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_in;
      end
      if (en) begin
        s[k]    <= s_in;
        root[k] <= take ? (r_in | (RT_W'(1) << B)) : r_in;
        rsq[k]  <= take ? trial : q_in;
        tag[k]  <= t_in;
      end
    end
  end

  assign out_valid = vld[RT_W-1];
  assign out_root  = root[RT_W-1];
  assign out_tag   = tag[RT_W-1];

endmodule

FILE: src/point_to_segment_distance_unit.sv
// point to line segment distance, fixed point, fully pipelined
// one word per cycle when not stalled; 16 divider and 27 square root stages
// a result stall freezes the whole pipeline, no word is lost or repeated
// reset (rst, synchronous) clears all valid bits; data registers are not reset
// depends on psd_pkg, psd_div, psd_sqrt
module point_to_segment_distance_unit import psd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        query_valid,
  output logic        query_stall,
  input  psd_query_t  query,
  output logic        result_valid,
  input  logic        result_stall,
  output psd_result_t result
);

  logic en;
  assign en          = !(result_valid && result_stall);
  assign query_stall = !en;

  // stage 1: differences
  logic                  v1;
  logic signed [D_W-1:0] apx1, apy1, abx1, aby1;

  // stage 2: products
  logic                    v2;
  logic signed [2*D_W-1:0] sqx2, sqy2, dpx2, dpy2;
  logic signed [D_W-1:0]   apx2, apy2, abx2, aby2;

  // stage 3: length and dot product
  logic                    v3;
  logic [LEN_W-1:0]        len3;
  logic signed [DOT_W-1:0] dot3;
  logic signed [D_W-1:0]   apx3, apy3, abx3, aby3;

  // stage 4: divider feed
  logic             v4;
  logic [LEN_W-1:0] rem4, den4;
  psd_carry_t       c4;

  logic                       vd;
  logic [T_FRACTION_BITS-1:0] qd;
  psd_carry_t                 cd;

  // stage 5: offset products
  logic                  v5;
  logic [PROD_W-1:0]     prx5, pry5;
  logic signed [D_W-1:0] apx5, apy5;
  logic                  nx5, ny5;
  psd_tag_t              tag5;

  // stage 6: distance components
  logic                   v6;
  logic signed [DX_W-1:0] dx6, dy6;
  psd_tag_t               tag6;

  // stage 7: squares
  logic                     v7;
  logic signed [2*DX_W-1:0] sx7, sy7;
  psd_tag_t                 tag7;

  // stage 8: sum
  logic            v8;
  logic [SQ_W-1:0] s8;
  psd_tag_t        tag8;

  logic            non_pos, ge_len;
  logic [TF_W-1:0] t_val;
  logic [D_W-1:0]  mabx, maby;
  logic [DX_W-1:0] offx, offy;

  assign non_pos = dot3 <= 0;
  assign ge_len  = dot3 >= $signed({2'b00, len3});

  always_comb begin
    if (cd.t_zero) begin
      t_val = '0;
    end else if (cd.t_one) begin
      t_val = TF_W'(1) << T_FRACTION_BITS;
    end else begin
      t_val = {1'b0, qd};
    end
    mabx = cd.abx[D_W-1] ? D_W'(-cd.abx) : D_W'(cd.abx);
    maby = cd.aby[D_W-1] ? D_W'(-cd.aby) : D_W'(cd.aby);
    offx = DX_W'(prx5 >> T_FRACTION_BITS);
    offy = DX_W'(pry5 >> T_FRACTION_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else if (en) begin
      v1 <= query_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= vd;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
    end
    if (en) begin
      apx1 <= D_W'(query.point_x) - D_W'(query.start_x);
      apy1 <= D_W'(query.point_y) - D_W'(query.start_y);
      abx1 <= D_W'(query.end_x) - D_W'(query.start_x);
      aby1 <= D_W'(query.end_y) - D_W'(query.start_y);

      sqx2 <= abx1 * abx1;
      sqy2 <= aby1 * aby1;
      dpx2 <= apx1 * abx1;
      dpy2 <= apy1 * aby1;
      apx2 <= apx1;
      apy2 <= apy1;
      abx2 <= abx1;
      aby2 <= aby1;

      len3 <= LEN_W'(sqx2) + LEN_W'(sqy2);
      dot3 <= DOT_W'(dpx2) + DOT_W'(dpy2);
      apx3 <= apx2;
      apy3 <= apy2;
      abx3 <= abx2;
      aby3 <= aby2;

      rem4           <= (non_pos || ge_len) ? '0 : LEN_W'(dot3);
      den4           <= len3;
      c4.apx         <= apx3;
      c4.apy         <= apy3;
      c4.abx         <= abx3;
      c4.aby         <= aby3;
      c4.zero_length <= len3 == '0;
      c4.t_zero      <= (len3 == '0) || non_pos;
      c4.t_one       <= ge_len;

      prx5            <= PROD_W'(mabx) * PROD_W'(t_val);
      pry5            <= PROD_W'(maby) * PROD_W'(t_val);
      apx5            <= cd.apx;
      apy5            <= cd.apy;
      nx5             <= cd.abx[D_W-1];
      ny5             <= cd.aby[D_W-1];
      tag5.t_fraction <= t_val;
      tag5.zero_length <= cd.zero_length;

      dx6  <= nx5 ? DX_W'(apx5) + $signed(offx) : DX_W'(apx5) - $signed(offx);
      dy6  <= ny5 ? DX_W'(apy5) + $signed(offy) : DX_W'(apy5) - $signed(offy);
      tag6 <= tag5;

      sx7  <= dx6 * dx6;
      sy7  <= dy6 * dy6;
      tag7 <= tag6;

      s8   <= SQ_W'(unsigned'(sx7)) + SQ_W'(unsigned'(sy7));
      tag8 <= tag7;
    end
  end

  psd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .in_rem    (rem4),
    .in_den    (den4),
    .in_carry  (c4),
    .out_valid (vd),
    .out_q     (qd),
    .out_carry (cd)
  );

  logic [RT_W-1:0] root;
  psd_tag_t        tag_o;

  psd_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v8),
    .in_sq     (s8),
    .in_tag    (tag8),
    .out_valid (result_valid),
    .out_root  (root),
    .out_tag   (tag_o)
  );

  assign result.distance    = DIST_W'(root);
  assign result.t_fraction  = TOUT_W'(tag_o.t_fraction);
  assign result.zero_length = tag_o.zero_length;

endmodule
